FILE: hdl/ttf_pkg.sv
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared widths, latencies and types of the triangle tangent frame pipeline.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int OUT_FRAC_BITS = 14;

    localparam int EDGE_W   = 32;
    localparam int DUV_W    = 20;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = EDGE_W + DUV_W;
    localparam int DET_W    = 2 * DUV_W;
    localparam int RAW_W    = PROD_W + 1;
    localparam int MAG_W    = PROD_W;
    localparam int POS_W    = $clog2(MAG_W);
    localparam int A_W      = 30;
    localparam int SQ_W     = 2 * A_W + 2;
    localparam int RT_W     = SQ_W / 2;
    localparam int REM_W    = RT_W + 2;
    localparam int SQ_STEPS = RT_W;
    localparam int Q_W      = OUT_FRAC_BITS + 1;
    localparam int NUM_W    = A_W + OUT_FRAC_BITS + 1;
    localparam int NORM_LAT = 7 + SQ_STEPS + Q_W;
    localparam int PIPE_LAT = 3 + NORM_LAT + 1;

    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic signed [OUT_W-1:0] t_comp;

endpackage

FILE: hdl/ttf_norm.sv
// ----------------------------------------------------------------------------
// ttf_norm
// Pipelined normaliser: three magnitudes with signs to a unit vector in
// Q1.OUT_FRAC_BITS, via common scaling, squared sum, digit square root and
// a restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module ttf_norm (
    input  logic             i_clk,
    input  logic             i_en,
    input  ttf_pkg::t_mag    i_mag [3],
    input  logic [2:0]       i_neg,
    output ttf_pkg::t_comp   o_comp [3],
    output logic             o_zero
);
    import ttf_pkg::*;

    // scale, square and sum stages
    t_mag               r1_a [3];
    t_mag               r1_m;
    logic [2:0]         r1_neg;
    t_mag               r2_a [3];
    logic [POS_W-1:0]   r2_p;
    logic [2:0]         r2_neg;
    logic               r2_zero;
    logic [A_W-1:0]     r3_a [3];
    logic [2:0]         r3_neg;
    logic               r3_zero;
    logic [2*A_W-1:0]   r4_sq [3];
    logic [A_W-1:0]     r4_a [3];
    logic [2:0]         r4_neg;
    logic               r4_zero;
    logic [SQ_W-1:0]    r5_s;
    logic [A_W-1:0]     r5_a [3];
    logic [2:0]         r5_neg;
    logic               r5_zero;

    t_mag               n_max;
    logic [POS_W-1:0]   n_pos;
    logic [A_W-1:0]     n_sh [3];

    always_comb begin
        n_max = r1_a[0];
        if (i_mag[1] > i_mag[0]) begin
            n_max = i_mag[1];
        end else begin
            n_max = i_mag[0];
        end
        if (i_mag[2] > n_max) begin
            n_max = i_mag[2];
        end
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r1_m[b]) begin
                n_pos = POS_W'(b);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r2_p >= POS_W'(A_W - 1)) begin
                n_sh[i] = A_W'(r2_a[i] >> (r2_p - POS_W'(A_W - 1)));
            end else begin
                n_sh[i] = A_W'(r2_a[i] << (POS_W'(A_W - 1) - r2_p));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= i_mag;
            r1_m    <= n_max;
            r1_neg  <= i_neg;
            r2_a    <= r1_a;
            r2_p    <= n_pos;
            r2_neg  <= r1_neg;
            r2_zero <= (r1_m == '0);
            r3_a    <= n_sh;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            for (int i = 0; i < 3; i++) begin
                r4_sq[i] <= (2*A_W)'(r3_a[i]) * (2*A_W)'(r3_a[i]);
            end
            r4_a    <= r3_a;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
            r5_s    <= SQ_W'(r4_sq[0]) + SQ_W'(r4_sq[1]) + SQ_W'(r4_sq[2]);
            r5_a    <= r4_a;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    // square root, one result bit per stage
    logic [SQ_W-1:0]  w_sq_s    [0:SQ_STEPS];
    logic [REM_W-1:0] w_sq_rem  [0:SQ_STEPS];
    logic [RT_W-1:0]  w_sq_root [0:SQ_STEPS];
    logic [A_W-1:0]   w_sq_a    [0:SQ_STEPS][3];
    logic [2:0]       w_sq_neg  [0:SQ_STEPS];
    logic             w_sq_zero [0:SQ_STEPS];

    assign w_sq_s[0]    = r5_s;
    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_a[0]    = r5_a;
    assign w_sq_neg[0]  = r5_neg;
    assign w_sq_zero[0] = r5_zero;

    for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
        logic [SQ_W-1:0]  r_s;
        logic [REM_W-1:0] r_rem;
        logic [RT_W-1:0]  r_root;
        logic [A_W-1:0]   r_a [3];
        logic [2:0]       r_neg;
        logic             r_zero;
        logic [REM_W+1:0] n_rx;
        logic [REM_W+1:0] n_trial;

        assign n_rx    = {w_sq_rem[k-1], w_sq_s[k-1][SQ_W+1-2*k -: 2]};
        assign n_trial = (REM_W+2)'({w_sq_root[k-1], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_rx >= n_trial) begin
                    r_rem  <= REM_W'(n_rx - n_trial);
                    r_root <= {w_sq_root[k-1][RT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(n_rx);
                    r_root <= {w_sq_root[k-1][RT_W-2:0], 1'b0};
                end
                r_s    <= w_sq_s[k-1];
                r_a    <= w_sq_a[k-1];
                r_neg  <= w_sq_neg[k-1];
                r_zero <= w_sq_zero[k-1];
            end
        end

        assign w_sq_s[k]    = r_s;
        assign w_sq_rem[k]  = r_rem;
        assign w_sq_root[k] = r_root;
        assign w_sq_a[k]    = r_a;
        assign w_sq_neg[k]  = r_neg;
        assign w_sq_zero[k] = r_zero;
    end

    // divide, numerator pre-rounded by half the length
    logic [NUM_W-1:0] w_dv_num  [0:Q_W][3];
    logic [Q_W-1:0]   w_dv_q    [0:Q_W][3];
    logic [RT_W-1:0]  w_dv_l    [0:Q_W];
    logic [2:0]       w_dv_neg  [0:Q_W];
    logic             w_dv_zero [0:Q_W];

    logic [NUM_W-1:0] r6_num [3];
    logic [RT_W-1:0]  r6_l;
    logic [2:0]       r6_neg;
    logic             r6_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r6_num[i] <= (NUM_W'(w_sq_a[SQ_STEPS][i]) << OUT_FRAC_BITS)
                             + NUM_W'(w_sq_root[SQ_STEPS] >> 1);
            end
            r6_l    <= w_sq_root[SQ_STEPS];
            r6_neg  <= w_sq_neg[SQ_STEPS];
            r6_zero <= w_sq_zero[SQ_STEPS];
        end
    end

    assign w_dv_num[0]  = r6_num;
    assign w_dv_l[0]    = r6_l;
    assign w_dv_neg[0]  = r6_neg;
    assign w_dv_zero[0] = r6_zero;
    for (genvar i = 0; i < 3; i++) begin : g_q0
        assign w_dv_q[0][i] = '0;
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_div
        logic [NUM_W-1:0] r_num [3];
        logic [Q_W-1:0]   r_q [3];
        logic [RT_W-1:0]  r_l;
        logic [2:0]       r_neg;
        logic             r_zero;
        logic [NUM_W-1:0] n_d;

        assign n_d = NUM_W'(w_dv_l[j-1]) << (Q_W - j);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (w_dv_num[j-1][i] >= n_d) begin
                        r_num[i] <= w_dv_num[j-1][i] - n_d;
                        r_q[i]   <= {w_dv_q[j-1][i][Q_W-2:0], 1'b1};
                    end else begin
                        r_num[i] <= w_dv_num[j-1][i];
                        r_q[i]   <= {w_dv_q[j-1][i][Q_W-2:0], 1'b0};
                    end
                end
                r_l    <= w_dv_l[j-1];
                r_neg  <= w_dv_neg[j-1];
                r_zero <= w_dv_zero[j-1];
            end
        end

        assign w_dv_num[j]  = r_num;
        assign w_dv_q[j]    = r_q;
        assign w_dv_l[j]    = r_l;
        assign w_dv_neg[j]  = r_neg;
        assign w_dv_zero[j] = r_zero;
    end

    // clamp, restore sign
    t_comp       r_out [3];
    logic        r_zero;
    logic [31:0] n_qc  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_dv_q[Q_W][i] > Q_W'(1 << OUT_FRAC_BITS)) begin
                n_qc[i] = 32'(1 << OUT_FRAC_BITS);
            end else begin
                n_qc[i] = 32'(w_dv_q[Q_W][i]);
            end
            if (w_dv_neg[Q_W][i]) begin
                n_qc[i] = 32'(0) - n_qc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= n_qc[i][OUT_W-1:0];
            end
            r_zero <= w_dv_zero[Q_W];
        end
    end

    assign o_comp = r_out;
    assign o_zero = r_zero;

endmodule

FILE: hdl/triangle_tangent_frame.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame
// Per-triangle unit tangent and bitangent from two position edges and two
// texture-coordinate deltas.
// ----------------------------------------------------------------------------
// Input channel: i_valid with the triangle fields; the block holds o_stall
// high while its output item is stalled. Output channel: o_valid with the
// frame fields; the receiver holds i_stall to keep it.
// Throughput is one triangle per cycle while the output item is not stalled.
// From acceptance to o_valid: three stages of products and signs, then the
// normaliser (scaling 5, square root 31 one bit a stage, rounding 1,
// division 15 one quotient bit a stage, sign 1) and one output stage.
// A zero determinant or a zero-length vector gives o_degenerate with all
// six vector fields zero.
// Reset (synchronous, active low) clears every valid bit; payload stages
// are not reset. While the output item is stalled the whole pipeline holds
// and o_stall is raised, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_tangent_frame (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_edge_a_x,
    input  logic signed [31:0]          i_edge_a_y,
    input  logic signed [31:0]          i_edge_a_z,
    input  logic signed [31:0]          i_edge_b_x,
    input  logic signed [31:0]          i_edge_b_y,
    input  logic signed [31:0]          i_edge_b_z,
    input  logic signed [19:0]          i_duv_a_u,
    input  logic signed [19:0]          i_duv_a_v,
    input  logic signed [19:0]          i_duv_b_u,
    input  logic signed [19:0]          i_duv_b_v,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [15:0]          o_tan_x,
    output logic signed [15:0]          o_tan_y,
    output logic signed [15:0]          o_tan_z,
    output logic signed [15:0]          o_bitan_x,
    output logic signed [15:0]          o_bitan_y,
    output logic signed [15:0]          o_bitan_z,
    output logic                        o_degenerate
);
    import ttf_pkg::*;

    logic                     en;
    logic                     r_vld [1:PIPE_LAT];
    logic signed [EDGE_W-1:0] ea [3];
    logic signed [EDGE_W-1:0] eb [3];

    assign en      = !(r_vld[PIPE_LAT] && i_stall);
    assign o_stall = r_vld[PIPE_LAT] && i_stall;
    assign o_valid = r_vld[PIPE_LAT];

    assign ea[0] = i_edge_a_x;
    assign ea[1] = i_edge_a_y;
    assign ea[2] = i_edge_a_z;
    assign eb[0] = i_edge_b_x;
    assign eb[1] = i_edge_b_y;
    assign eb[2] = i_edge_b_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= PIPE_LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_valid;
            for (int s = 2; s <= PIPE_LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // products
    logic signed [DET_W-1:0]  r1_d1, r1_d2;
    logic signed [PROD_W-1:0] r1_tp1 [3];
    logic signed [PROD_W-1:0] r1_tp2 [3];
    logic signed [PROD_W-1:0] r1_bp1 [3];
    logic signed [PROD_W-1:0] r1_bp2 [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d1 <= i_duv_a_u * i_duv_b_v;
            r1_d2 <= i_duv_b_u * i_duv_a_v;
            for (int i = 0; i < 3; i++) begin
                r1_tp1[i] <= i_duv_b_v * ea[i];
                r1_tp2[i] <= i_duv_a_v * eb[i];
                r1_bp1[i] <= i_duv_a_u * eb[i];
                r1_bp2[i] <= i_duv_b_u * ea[i];
            end
        end
    end

    // differences
    logic signed [DET_W:0]    r2_det;
    logic signed [RAW_W-1:0]  r2_t [3];
    logic signed [RAW_W-1:0]  r2_b [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_det <= (DET_W+1)'(r1_d1) - (DET_W+1)'(r1_d2);
            for (int i = 0; i < 3; i++) begin
                r2_t[i] <= RAW_W'(r1_tp1[i]) - RAW_W'(r1_tp2[i]);
                r2_b[i] <= RAW_W'(r1_bp1[i]) - RAW_W'(r1_bp2[i]);
            end
        end
    end

    // magnitudes and signs, determinant sign folded in
    t_mag       r3_tm [3];
    t_mag       r3_bm [3];
    logic [2:0] r3_tn;
    logic [2:0] r3_bn;
    logic       r3_ok;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_tm[i] <= r2_t[i][RAW_W-1] ? MAG_W'(-r2_t[i]) : MAG_W'(r2_t[i]);
                r3_bm[i] <= r2_b[i][RAW_W-1] ? MAG_W'(-r2_b[i]) : MAG_W'(r2_b[i]);
                r3_tn[i] <= r2_t[i][RAW_W-1] ^ r2_det[DET_W];
                r3_bn[i] <= r2_b[i][RAW_W-1] ^ r2_det[DET_W];
            end
            r3_ok <= (r2_det != '0);
        end
    end

    t_comp tan_c   [3];
    t_comp bitan_c [3];
    logic  tan_zero, bitan_zero;

    ttf_norm u_norm_tan (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r3_tm),
        .i_neg  (r3_tn),
        .o_comp (tan_c),
        .o_zero (tan_zero)
    );

    ttf_norm u_norm_bitan (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r3_bm),
        .i_neg  (r3_bn),
        .o_comp (bitan_c),
        .o_zero (bitan_zero)
    );

    logic r_okd [1:NORM_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_okd[1] <= r3_ok;
            for (int s = 2; s <= NORM_LAT; s++) begin
                r_okd[s] <= r_okd[s-1];
            end
        end
    end

    // output stage
    t_comp r_tan   [3];
    t_comp r_bitan [3];
    logic  r_degen;
    logic  n_ok;

    assign n_ok = r_okd[NORM_LAT] && !tan_zero && !bitan_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_tan[i]   <= n_ok ? tan_c[i]   : '0;
                r_bitan[i] <= n_ok ? bitan_c[i] : '0;
            end
            r_degen <= !n_ok;
        end
    end

    assign o_tan_x      = r_tan[0];
    assign o_tan_y      = r_tan[1];
    assign o_tan_z      = r_tan[2];
    assign o_bitan_x    = r_bitan[0];
    assign o_bitan_y    = r_bitan[1];
    assign o_bitan_z    = r_bitan[2];
    assign o_degenerate = r_degen;

endmodule

FILE: hdl/ttf_checker.sv
// ----------------------------------------------------------------------------
// ttf_checker
// Port-level checks of the tangent frame block, bound to the top level.
// ----------------------------------------------------------------------------
module ttf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_tan_x,
    input  logic signed [15:0] o_tan_y,
    input  logic signed [15:0] o_tan_z,
    input  logic signed [15:0] o_bitan_x,
    input  logic signed [15:0] o_bitan_y,
    input  logic signed [15:0] o_bitan_z,
    input  logic               o_degenerate
);

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_tan_x == 0 && o_tan_y == 0 && o_tan_z == 0
            && o_bitan_x == 0 && o_bitan_y == 0 && o_bitan_z == 0)
        else $error("degenerate item with non-zero vectors");

    a_unit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> (o_tan_x != 0 || o_tan_y != 0 || o_tan_z != 0)
            && (o_bitan_x != 0 || o_bitan_y != 0 || o_bitan_z != 0))
        else $error("unit vector is zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled output item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tan_x) && $stable(o_bitan_z)
            && $stable(o_degenerate))
        else $error("stalled output item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);

FILE: tb/sv/triangle_tangent_frame_checker.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame_checker
// Watches both channels of the tangent frame block. Each triangle accepted on
// the input is turned into its expected unit tangent and bitangent, and each
// frame accepted on the output is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_edge_a_x,
    input  logic signed [31:0] i_edge_a_y,
    input  logic signed [31:0] i_edge_a_z,
    input  logic signed [31:0] i_edge_b_x,
    input  logic signed [31:0] i_edge_b_y,
    input  logic signed [31:0] i_edge_b_z,
    input  logic signed [19:0] i_duv_a_u,
    input  logic signed [19:0] i_duv_a_v,
    input  logic signed [19:0] i_duv_b_u,
    input  logic signed [19:0] i_duv_b_v,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_tan_x,
    input  logic signed [15:0] i_tan_y,
    input  logic signed [15:0] i_tan_z,
    input  logic signed [15:0] i_bitan_x,
    input  logic signed [15:0] i_bitan_y,
    input  logic signed [15:0] i_bitan_z,
    input  logic               i_degenerate,
    output int                 o_failures,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ttf_pkg::*;

    typedef struct packed {
        t_comp tx, ty, tz, bx, by, bz;
        logic  degen;
    } t_frame;

    t_frame frames_due[$];
    int     failures = 0;
    int     n_due = 0;

    assign o_failures = failures;
    assign o_pending  = n_due;

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // returns 0 for the zero vector
    function automatic logic unit_dir(input longint c[3], output t_comp o[3]);
        logic [63:0] a[3], m, s, len, q, lim;
        int          nb;
        m  = 0;
        s  = 0;
        nb = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = c[i] < 0 ? -c[i] : c[i];
            if (a[i] > m) m = a[i];
        end
        if (m == 0) return 1'b0;
        while (m != 0) begin
            nb++;
            m = m >> 1;
        end
        for (int i = 0; i < 3; i++) begin
            a[i] = nb > 30 ? a[i] >> (nb - 30) : a[i] << (30 - nb);
            s += a[i] * a[i];
        end
        len = root_floor(s);
        lim = 64'd1 << OUT_FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << OUT_FRAC_BITS) + (len >> 1)) / len;
            if (q > lim) q = lim;
            o[i] = c[i] < 0 ? t_comp'(-q) : t_comp'(q);
        end
        return 1'b1;
    endfunction

    function automatic t_frame frame_of(longint ea[3], longint eb[3],
                                        longint au, longint av,
                                        longint bu, longint bv);
        longint tv[3], bt[3], det;
        t_comp  ot[3], ob[3];
        t_frame f;
        logic   ok;
        det = au * bv - bu * av;
        ok  = det != 0;
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                tv[i] = bv * ea[i] - av * eb[i];
                bt[i] = au * eb[i] - bu * ea[i];
                if (det < 0) begin
                    tv[i] = -tv[i];
                    bt[i] = -bt[i];
                end
            end
            ok = unit_dir(tv, ot);
            if (ok) ok = unit_dir(bt, ob);
        end
        f = '0;
        f.degen = !ok;
        if (ok) begin
            f.tx = ot[0]; f.ty = ot[1]; f.tz = ot[2];
            f.bx = ob[0]; f.by = ob[1]; f.bz = ob[2];
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame want, got;
        longint ea[3], eb[3];
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            ea[0] = i_edge_a_x; ea[1] = i_edge_a_y; ea[2] = i_edge_a_z;
            eb[0] = i_edge_b_x; eb[1] = i_edge_b_y; eb[2] = i_edge_b_z;
            frames_due.push_back(frame_of(ea, eb, i_duv_a_u, i_duv_a_v,
                                          i_duv_b_u, i_duv_b_v));
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = {i_tan_x, i_tan_y, i_tan_z, i_bitan_x, i_bitan_y, i_bitan_z,
                   i_degenerate};
            if (frames_due.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected frame %h", got);
            end else begin
                want = frames_due.pop_front();
                if (got !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("frame mismatch: tan %0d %0d %0d / %0d %0d %0d bitan %0d %0d %0d / %0d %0d %0d degen %0b / %0b",
                                 want.tx, want.ty, want.tz, got.tx, got.ty, got.tz,
                                 want.bx, want.by, want.bz, got.bx, got.by, got.bz,
                                 want.degen, got.degen);
                end
            end
        end
        n_due = frames_due.size();
    end

endmodule

FILE: tb/sv/triangle_tangent_frame_test.sv
// ----------------------------------------------------------------------------
// triangle_tangent_frame_test
// Drives triangles into the tangent frame block with random gaps and output
// stalls: a directed set of corner cases, then random and degenerate
// triangles. The checker alongside predicts and compares every frame.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttf_pkg::*;

    logic               clk = 0, rst_n = 0;
    logic               in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic signed [31:0] ea_x = 0, ea_y = 0, ea_z = 0, eb_x = 0, eb_y = 0, eb_z = 0;
    logic signed [19:0] au = 0, av = 0, bu = 0, bv = 0;
    logic signed [15:0] tx, ty, tz, bx, by, bz;
    logic               degen;
    int                 failures, pending;
    logic               calm = 0;

    localparam logic signed [31:0] EMAX = 32'sh7fffffff, EMIN = 32'sh80000000;
    localparam logic signed [19:0] UMAX = 20'sh7ffff, UMIN = 20'sh80000;

    initial forever #2 clk = ~clk;

    triangle_tangent_frame u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_edge_a_x(ea_x), .i_edge_a_y(ea_y), .i_edge_a_z(ea_z),
        .i_edge_b_x(eb_x), .i_edge_b_y(eb_y), .i_edge_b_z(eb_z),
        .i_duv_a_u(au), .i_duv_a_v(av), .i_duv_b_u(bu), .i_duv_b_v(bv),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_tan_x(tx), .o_tan_y(ty), .o_tan_z(tz),
        .o_bitan_x(bx), .o_bitan_y(by), .o_bitan_z(bz), .o_degenerate(degen)
    );

    triangle_tangent_frame_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_edge_a_x(ea_x), .i_edge_a_y(ea_y), .i_edge_a_z(ea_z),
        .i_edge_b_x(eb_x), .i_edge_b_y(eb_y), .i_edge_b_z(eb_z),
        .i_duv_a_u(au), .i_duv_a_v(av), .i_duv_b_u(bu), .i_duv_b_v(bv),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_tan_x(tx), .i_tan_y(ty), .i_tan_z(tz),
        .i_bitan_x(bx), .i_bitan_y(by), .i_bitan_z(bz), .i_degenerate(degen),
        .o_failures(failures), .o_pending(pending)
    );

    always @(posedge clk)
        out_stall <= rst_n && !calm && ($urandom_range(99) < 33);

    task automatic send_triangle(logic signed [31:0] ax, ay, az, bxx, byy, bzz,
                                 logic signed [19:0] u0, v0, u1, v1);
        while (!calm && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ea_x <= ax; ea_y <= ay; ea_z <= az;
        eb_x <= bxx; eb_y <= byy; eb_z <= bzz;
        au <= u0; av <= v0; bu <= u1; bv <= v1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_edge();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed(32'($urandom_range(65535))) - 32768;
            2: return $urandom_range(1) ? EMAX : EMIN;
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    function automatic logic signed [19:0] rand_duv();
        case ($urandom_range(3))
            0: return 20'($urandom);
            1: return $signed(20'($urandom_range(15))) - 8;
            2: return $urandom_range(1) ? UMAX : UMIN;
            default: return $signed(20'($urandom)) >>> $urandom_range(19);
        endcase
    endfunction

    initial begin
        logic signed [19:0] u0, v0, u1, v1;
        logic signed [31:0] ax, ay, az;
        int                 k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit square, identity mapping
        send_triangle(32'sh10000, 0, 0, 0, 32'sh10000, 0, 20'sh10000, 0, 0, 20'sh10000);
        // mirrored uv: negative determinant
        send_triangle(32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 20'sh10000, 20'sh10000, 0);
        // zero determinant
        send_triangle(1, 2, 3, 4, 5, 6, 20'sh100, 20'sh200, 20'sh200, 20'sh400);
        send_triangle(EMAX, EMAX, EMAX, EMIN, EMIN, EMIN, 0, 0, 0, 0);
        // collinear edges: parallel tangent and bitangent; zero edges: zero-length vectors
        send_triangle(5, 7, 9, 10, 14, 18, 20'sh10000, 0, 0, 20'sh10000);
        send_triangle(0, 0, 0, 0, 0, 0, 20'sh10000, 0, 0, 20'sh10000);
        // full-range extremes
        send_triangle(EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, UMAX, UMIN, UMIN, UMAX);
        send_triangle(EMIN, EMIN, EMIN, EMAX, 0, EMIN, UMIN, UMAX, UMAX, UMAX);
        send_triangle(EMIN, 0, 0, 0, EMIN, 0, UMIN, 0, 0, UMIN);
        send_triangle(-1, -1, -1, 1, -1, 1, 20'sh1, 0, 0, -20'sh1);
        send_triangle(1, 0, 0, 0, 1, 0, UMAX, 20'sh1, 20'sh1, UMAX);
        // single axis tangent: clamp to one exactly
        send_triangle(0, 0, EMAX, EMAX, 0, 0, 0, 20'sh1, 20'sh1, 0);
        send_triangle(32'sh7fff0000, 32'sh1, 0, 0, 0, -32'sh7fff, 20'sh3, UMIN, 20'sh7, UMAX);

        for (int n = 0; n < 900; n++) begin
            calm = (n >= 300 && n < 450);
            u0 = rand_duv(); v0 = rand_duv(); u1 = rand_duv(); v1 = rand_duv();
            k = $urandom_range(9);
            if (k == 0) begin
                // doubled uv rows: zero determinant unless the doubling wraps
                u1 = u0 * 2; v1 = v0 * 2;
            end
            ax = rand_edge(); ay = rand_edge(); az = rand_edge();
            if (k == 1)
                send_triangle(ax, ay, az, ax, ay, az, u0, v0, u1, v1);
            else
                send_triangle(ax, ay, az, rand_edge(), rand_edge(), rand_edge(),
                              u0, v0, u1, v1);
        end
        in_valid <= 1'b0;
        calm = 0;
        while (pending != 0) @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
